// ===== src/fmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmsp_pkg
// Shared types and constants for the FLAC metadata stream parser.
// ----------------------------------------------------------------------------
package fmsp_pkg;

    // parser phases
    typedef enum logic [3:0] {
        PH_HEAD    = 4'd0,
        PH_ID3HDR  = 4'd1,
        PH_ID3SKIP = 4'd2,
        PH_MAGIC   = 4'd3,
        PH_BHDR    = 4'd4,
        PH_SKIP    = 4'd5,
        PH_INFO    = 4'd6,
        PH_VLEN    = 4'd7,
        PH_VSKIP   = 4'd8,
        PH_TCOUNT  = 4'd9,
        PH_TLEN    = 4'd10,
        PH_TBYTES  = 4'd11,
        PH_DONE    = 4'd12
    } t_phase;

    // result kinds
    typedef enum logic [2:0] {
        KIND_INFO     = 3'd0,
        KIND_COUNT    = 3'd1,
        KIND_TAG      = 3'd2,
        KIND_NOT_FLAC = 3'd3,
        KIND_END      = 3'd4
    } t_kind;

    // metadata block types of interest
    localparam logic [6:0] BLK_STREAMINFO = 7'd0;
    localparam logic [6:0] BLK_VORBIS     = 7'd4;

    // magic words
    localparam logic [23:0] ID3_MAGIC  = 24'h494433;
    localparam logic [31:0] FLAC_MAGIC = 32'h664C6143;

    // byte positions inside headers
    localparam logic [3:0] POS_WORD_LAST  = 4'd3;
    localparam logic [3:0] POS_ID3_FIRST  = 4'd6;
    localparam logic [3:0] POS_ID3_LAST   = 4'd9;
    localparam logic [3:0] POS_INFO_FIRST = 4'd10;
    localparam logic [3:0] POS_INFO_LAST  = 4'd13;

    // one input item as held in the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    // handshake between front queue and back parser
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [19:0] sample_rate;
        logic [5:0]  bits_per_sample;
        logic [3:0]  channel_count;
        logic [31:0] tag_count;
        logic [31:0] tag_index;
        logic [7:0]  tag_byte;
        logic        tag_last_byte;
        logic        metadata_done;
    } t_result;

endpackage

// ===== src/flac_metadata_stream_parser_core.sv =====
// ----------------------------------------------------------------------------
// flac_metadata_stream_parser_core
// Byte-stream parser for FLAC headers: ID3 skip, magic check, stream info
// and Vorbis comment tags.
// ----------------------------------------------------------------------------
// One file byte is accepted per clock. Bytes land in a small queue
// (QUEUE_DEPTH items) and the parser retires one queued byte every clock
// in which its result register is empty or being taken, so the sustained
// rate is one byte per cycle; a byte's result, if it has one, is presented
// from the result register after the byte leaves the queue. A stall at the
// output backs up into the queue and only then drops o_in_ready. Setting
// i_file_start on a byte restarts parsing with that byte as the first of a
// new file; before any start the block behaves as if one had just occurred.
// ----------------------------------------------------------------------------
module flac_metadata_stream_parser_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic [19:0] o_sample_rate,
    output logic [5:0]  o_bits_per_sample,
    output logic [3:0]  o_channel_count,
    output logic [31:0] o_tag_count,
    output logic [31:0] o_tag_index,
    output logic [7:0]  o_tag_byte,
    output logic        o_tag_last_byte,
    output logic        o_metadata_done
);

    fmsp_pkg::t_queue_head head;
    fmsp_pkg::t_result     result;
    logic                  pop;

    // input queue
    fmsp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_head       (head),
        .i_pop        (pop)
    );

    // parser and result register
    fmsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    // result fields
    assign o_result_kind     = result.kind;
    assign o_sample_rate     = result.sample_rate;
    assign o_bits_per_sample = result.bits_per_sample;
    assign o_channel_count   = result.channel_count;
    assign o_tag_count       = result.tag_count;
    assign o_tag_index       = result.tag_index;
    assign o_tag_byte        = result.tag_byte;
    assign o_tag_last_byte   = result.tag_last_byte;
    assign o_metadata_done   = result.metadata_done;

endmodule

// ===== src/fmsp_front.sv =====
// ----------------------------------------------------------------------------
// fmsp_front
// Input side: accepts byte items and holds them in a short queue for the parser.
// ----------------------------------------------------------------------------
module fmsp_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_file_start,
    output fmsp_pkg::t_queue_head o_head,
    input  logic                  i_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    fmsp_pkg::t_in_item r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          push;
    logic          pop;

    // handshake
    assign o_in_ready = (r_count != CNT_FULL);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && (r_count != '0);

    // queue head toward the parser
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data_byte: i_data_byte, file_start: i_file_start};
        end
    end

endmodule

// ===== src/fmsp_back.sv =====
// ----------------------------------------------------------------------------
// fmsp_back
// Parser: walks the ID3 header, magic, block headers and block bodies, one
// queued byte per clock unless the result register stalls, and drives it.
// ----------------------------------------------------------------------------
module fmsp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fmsp_pkg::t_queue_head i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fmsp_pkg::t_result     o_result
);

    fmsp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [3:0]  r_pos,  n_pos,  e_pos;
    logic [31:0] r_skip, n_skip, e_skip;
    logic [31:0] r_hs,   n_hs,   e_hs;
    logic [23:0] r_rem,  n_rem,  e_rem;
    logic        r_last, n_last, e_last;
    logic [31:0] r_tags_total, n_tags_total, e_tags_total;
    logic [31:0] r_tag_number, n_tag_number, e_tag_number;
    logic [31:0] r_tbl,  n_tbl,  e_tbl;
    logic [31:0] r_info, n_info, e_info;

    logic              r_out_valid;
    fmsp_pkg::t_result r_result;
    fmsp_pkg::t_result res;
    logic              res_have;

    logic [7:0]  b;
    logic [31:0] hs_be;
    logic [31:0] hs_le;
    logic [31:0] info_next;
    logic [31:0] skip_id3;
    logic [23:0] rem_dec;
    logic [3:0]  pos_inc;
    logic [31:0] tag_num_inc;
    logic [31:0] tbl_dec;
    logic [31:0] skip_dec;
    logic        word_done;
    logic        is_body;
    logic        hdr_end;
    logic        body_end;
    logic        block_end;
    logic        last_at_end;

    // pop when the result register is free or draining
    assign o_pop = i_head.valid && (!r_out_valid || i_out_ready);

    // a start flag makes this byte the first of a fresh file
    always_comb begin
        if (i_head.item.file_start) begin
            e_phase      = fmsp_pkg::PH_HEAD;
            e_pos        = '0;
            e_skip       = '0;
            e_hs         = '0;
            e_rem        = '0;
            e_last       = 1'b0;
            e_tags_total = '0;
            e_tag_number = '0;
            e_tbl        = '0;
            e_info       = '0;
        end else begin
            e_phase      = r_phase;
            e_pos        = r_pos;
            e_skip       = r_skip;
            e_hs         = r_hs;
            e_rem        = r_rem;
            e_last       = r_last;
            e_tags_total = r_tags_total;
            e_tag_number = r_tag_number;
            e_tbl        = r_tbl;
            e_info       = r_info;
        end
    end

    // shared datapath terms
    assign b           = i_head.item.data_byte;
    assign hs_be       = {e_hs[23:0], b};
    assign hs_le       = e_hs | (32'(b) << {e_pos[1:0], 3'b000});
    assign info_next   = {e_info[23:0], b};
    assign skip_id3    = (e_pos >= fmsp_pkg::POS_ID3_FIRST) ?
                         {e_skip[24:0], b[6:0]} : e_skip;
    assign rem_dec     = e_rem - 24'd1;
    assign pos_inc     = e_pos + 4'd1;
    assign tag_num_inc = e_tag_number + 32'd1;
    assign tbl_dec     = e_tbl - 32'd1;
    assign skip_dec    = e_skip - 32'd1;
    assign word_done   = (e_pos == fmsp_pkg::POS_WORD_LAST);

    assign is_body = (e_phase == fmsp_pkg::PH_SKIP)   || (e_phase == fmsp_pkg::PH_INFO)  ||
                     (e_phase == fmsp_pkg::PH_VLEN)   || (e_phase == fmsp_pkg::PH_VSKIP) ||
                     (e_phase == fmsp_pkg::PH_TCOUNT) || (e_phase == fmsp_pkg::PH_TLEN)  ||
                     (e_phase == fmsp_pkg::PH_TBYTES);

    // end of block, from an empty header or the last body byte
    assign hdr_end     = (e_phase == fmsp_pkg::PH_BHDR) && word_done && (hs_be[23:0] == '0);
    assign body_end    = is_body && (rem_dec == '0);
    assign block_end   = hdr_end || body_end;
    assign last_at_end = hdr_end ? hs_be[31] : e_last;

    // next state
    always_comb begin
        n_phase      = e_phase;
        n_pos        = e_pos;
        n_skip       = e_skip;
        n_hs         = e_hs;
        n_rem        = e_rem;
        n_last       = e_last;
        n_tags_total = e_tags_total;
        n_tag_number = e_tag_number;
        n_tbl        = e_tbl;
        n_info       = e_info;
        if (is_body) begin
            n_rem = rem_dec;
        end
        case (e_phase)
            fmsp_pkg::PH_HEAD: begin
                n_hs  = hs_be;
                n_pos = pos_inc;
                if (word_done) begin
                    n_hs = '0;
                    if (hs_be[31:8] == fmsp_pkg::ID3_MAGIC) begin
                        n_phase = fmsp_pkg::PH_ID3HDR;
                        n_skip  = '0;
                    end else if (hs_be == fmsp_pkg::FLAC_MAGIC) begin
                        n_phase = fmsp_pkg::PH_BHDR;
                        n_pos   = '0;
                    end else begin
                        n_phase = fmsp_pkg::PH_DONE;
                    end
                end
            end
            fmsp_pkg::PH_ID3HDR: begin
                n_skip = skip_id3;
                n_pos  = pos_inc;
                if (e_pos == fmsp_pkg::POS_ID3_LAST) begin
                    n_pos   = '0;
                    n_hs    = '0;
                    n_phase = (skip_id3 != '0) ? fmsp_pkg::PH_ID3SKIP : fmsp_pkg::PH_MAGIC;
                end
            end
            fmsp_pkg::PH_ID3SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = fmsp_pkg::PH_MAGIC;
                end
            end
            fmsp_pkg::PH_MAGIC: begin
                n_hs  = hs_be;
                n_pos = pos_inc;
                if (word_done) begin
                    n_pos   = '0;
                    n_hs    = '0;
                    n_phase = (hs_be == fmsp_pkg::FLAC_MAGIC) ?
                              fmsp_pkg::PH_BHDR : fmsp_pkg::PH_DONE;
                end
            end
            fmsp_pkg::PH_BHDR: begin
                n_hs  = hs_be;
                n_pos = pos_inc;
                if (word_done) begin
                    n_last = hs_be[31];
                    n_rem  = hs_be[23:0];
                    n_pos  = '0;
                    n_hs   = '0;
                    n_info = '0;
                    if (hs_be[30:24] == fmsp_pkg::BLK_STREAMINFO) begin
                        n_phase = fmsp_pkg::PH_INFO;
                    end else if (hs_be[30:24] == fmsp_pkg::BLK_VORBIS) begin
                        n_phase = fmsp_pkg::PH_VLEN;
                    end else begin
                        n_phase = fmsp_pkg::PH_SKIP;
                    end
                end
            end
            fmsp_pkg::PH_INFO: begin
                if (e_pos >= fmsp_pkg::POS_INFO_FIRST) begin
                    n_info = info_next;
                end
                n_pos = pos_inc;
                if (e_pos == fmsp_pkg::POS_INFO_LAST) begin
                    n_phase = fmsp_pkg::PH_SKIP;
                end
            end
            fmsp_pkg::PH_VLEN: begin
                n_hs  = hs_le;
                n_pos = pos_inc;
                if (word_done) begin
                    n_pos   = '0;
                    n_hs    = '0;
                    n_skip  = hs_le;
                    n_phase = (hs_le != '0) ? fmsp_pkg::PH_VSKIP : fmsp_pkg::PH_TCOUNT;
                end
            end
            fmsp_pkg::PH_VSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = fmsp_pkg::PH_TCOUNT;
                end
            end
            fmsp_pkg::PH_TCOUNT: begin
                n_hs  = hs_le;
                n_pos = pos_inc;
                if (word_done) begin
                    n_pos        = '0;
                    n_hs         = '0;
                    n_tags_total = hs_le;
                    n_tag_number = '0;
                    n_phase      = (hs_le != '0) ? fmsp_pkg::PH_TLEN : fmsp_pkg::PH_SKIP;
                end
            end
            fmsp_pkg::PH_TLEN: begin
                n_hs  = hs_le;
                n_pos = pos_inc;
                if (word_done) begin
                    n_pos = '0;
                    n_hs  = '0;
                    if (hs_le == '0) begin
                        // empty tag is only counted
                        n_tag_number = tag_num_inc;
                        if (tag_num_inc == e_tags_total) begin
                            n_phase = fmsp_pkg::PH_SKIP;
                        end
                    end else if (hs_le > {8'd0, rem_dec}) begin
                        n_phase = fmsp_pkg::PH_SKIP;
                    end else begin
                        n_tbl   = hs_le;
                        n_phase = fmsp_pkg::PH_TBYTES;
                    end
                end
            end
            fmsp_pkg::PH_TBYTES: begin
                n_tbl = tbl_dec;
                if (tbl_dec == '0) begin
                    n_tag_number = tag_num_inc;
                    n_phase      = (tag_num_inc == e_tags_total) ?
                                   fmsp_pkg::PH_SKIP : fmsp_pkg::PH_TLEN;
                end
            end
            default: begin
            end
        endcase
        if (block_end) begin
            n_pos   = '0;
            n_hs    = '0;
            n_phase = last_at_end ? fmsp_pkg::PH_DONE : fmsp_pkg::PH_BHDR;
        end
    end

    // result for this byte
    always_comb begin
        res_have = 1'b0;
        res      = '0;
        case (e_phase)
            fmsp_pkg::PH_HEAD: begin
                if (word_done && (hs_be[31:8] != fmsp_pkg::ID3_MAGIC) &&
                    (hs_be != fmsp_pkg::FLAC_MAGIC)) begin
                    res_have = 1'b1;
                    res.kind = fmsp_pkg::KIND_NOT_FLAC;
                end
            end
            fmsp_pkg::PH_MAGIC: begin
                if (word_done && (hs_be != fmsp_pkg::FLAC_MAGIC)) begin
                    res_have = 1'b1;
                    res.kind = fmsp_pkg::KIND_NOT_FLAC;
                end
            end
            fmsp_pkg::PH_INFO: begin
                if (e_pos == fmsp_pkg::POS_INFO_LAST) begin
                    res_have            = 1'b1;
                    res.kind            = fmsp_pkg::KIND_INFO;
                    res.sample_rate     = info_next[31:12];
                    res.bits_per_sample = {1'b0, info_next[8:4]} + 6'd1;
                    res.channel_count   = {1'b0, info_next[11:9]} + 4'd1;
                end
            end
            fmsp_pkg::PH_TCOUNT: begin
                if (word_done) begin
                    res_have      = 1'b1;
                    res.kind      = fmsp_pkg::KIND_COUNT;
                    res.tag_count = hs_le;
                end
            end
            fmsp_pkg::PH_TLEN: begin
                if (word_done && (hs_le != '0) && (hs_le > {8'd0, rem_dec})) begin
                    res_have      = 1'b1;
                    res.kind      = fmsp_pkg::KIND_END;
                    res.tag_count = e_tags_total;
                    res.tag_index = e_tag_number;
                end
            end
            fmsp_pkg::PH_TBYTES: begin
                res_have          = 1'b1;
                res.kind          = fmsp_pkg::KIND_TAG;
                res.tag_count     = e_tags_total;
                res.tag_index     = e_tag_number;
                res.tag_byte      = b;
                res.tag_last_byte = (tbl_dec == '0);
            end
            default: begin
            end
        endcase
        // end of the last block marks whatever result goes out, or makes one
        if (block_end && last_at_end) begin
            if (!res_have) begin
                res_have = 1'b1;
                res.kind = fmsp_pkg::KIND_END;
            end
            res.metadata_done = 1'b1;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= fmsp_pkg::PH_HEAD;
            r_pos        <= '0;
            r_skip       <= '0;
            r_hs         <= '0;
            r_rem        <= '0;
            r_last       <= 1'b0;
            r_tags_total <= '0;
            r_tag_number <= '0;
            r_tbl        <= '0;
            r_info       <= '0;
        end else if (o_pop) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_skip       <= n_skip;
            r_hs         <= n_hs;
            r_rem        <= n_rem;
            r_last       <= n_last;
            r_tags_total <= n_tags_total;
            r_tag_number <= n_tag_number;
            r_tbl        <= n_tbl;
            r_info       <= n_info;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && res_have) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_have) begin
            r_result <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// ===== src/fmsp_checker.sv =====
// ----------------------------------------------------------------------------
// fmsp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fmsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_result_kind,
    input logic [19:0] o_sample_rate,
    input logic [5:0]  o_bits_per_sample,
    input logic [3:0]  o_channel_count,
    input logic [31:0] o_tag_count,
    input logic [31:0] o_tag_index,
    input logic [7:0]  o_tag_byte,
    input logic        o_tag_last_byte,
    input logic        o_metadata_done
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind) &&
        $stable(o_tag_index) && $stable(o_tag_byte) && $stable(o_metadata_done))
        else $error("result changed while stalled");

    // tag end marker only on tag bytes
    a_last_on_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tag_last_byte |-> o_result_kind == fmsp_pkg::KIND_TAG)
        else $error("tag end marker outside a tag byte");

    // stream info fields zero in other kinds
    a_info_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != fmsp_pkg::KIND_INFO) |->
        (o_sample_rate == '0) && (o_bits_per_sample == '0) && (o_channel_count == '0))
        else $error("stream info fields set outside stream info");

    // a bad magic result carries nothing else
    a_not_flac_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == fmsp_pkg::KIND_NOT_FLAC) |->
        !o_metadata_done && (o_tag_count == '0) && (o_tag_index == '0))
        else $error("bad magic result carries extra fields");

endmodule

bind flac_metadata_stream_parser_core fmsp_checker u_fmsp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_result_kind     (o_result_kind),
    .o_sample_rate     (o_sample_rate),
    .o_bits_per_sample (o_bits_per_sample),
    .o_channel_count   (o_channel_count),
    .o_tag_count       (o_tag_count),
    .o_tag_index       (o_tag_index),
    .o_tag_byte        (o_tag_byte),
    .o_tag_last_byte   (o_tag_last_byte),
    .o_metadata_done   (o_metadata_done)
);

// ===== tb/sv/flac_parse_sb_pkg.sv =====
// ----------------------------------------------------------------------------
// flac_parse_sb_pkg
// Scoreboard for the FLAC metadata stream parser: a byte-level model of the
// header walk predicts each result item, and results from the block are
// checked in order against it.
// ----------------------------------------------------------------------------
package flac_parse_sb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import fmsp_pkg::*;

    class flac_parse_sb;

        // parser state
        t_phase      phase;
        logic [31:0] pos;
        logic [31:0] skip_left;
        logic [31:0] shift_acc;
        logic [23:0] blk_left;
        logic        last_blk;
        logic [31:0] tags_total;
        logic [31:0] tag_num;
        logic [31:0] tag_left;
        logic [31:0] info_acc;

        // results still to come from the block, oldest first
        t_result     awaited[$];
        int          errors;
        int          kind_seen[5];

        function new();
            clear_state();
            errors = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void clear_state();
            phase      = PH_HEAD;
            pos        = '0;
            skip_left  = '0;
            shift_acc  = '0;
            blk_left   = '0;
            last_blk   = 1'b0;
            tags_total = '0;
            tag_num    = '0;
            tag_left   = '0;
            info_acc   = '0;
        endfunction

        // little-endian word collect, true once four bytes are in
        function bit take_le(logic [7:0] b);
            shift_acc = shift_acc | (32'(b) << (8 * pos[1:0]));
            pos++;
            if (pos >= 4) begin
                pos = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // current block finishes on this byte
        function void end_block(inout bit have, inout t_result r);
            pos       = '0;
            shift_acc = '0;
            if (last_blk) begin
                phase = PH_DONE;
                if (!have) begin
                    have   = 1'b1;
                    r.kind = KIND_END;
                end
                r.metadata_done = 1'b1;
            end else begin
                phase = PH_BHDR;
            end
        endfunction

        // one byte inside a metadata block body
        function void body_byte(logic [7:0] b, inout bit have, inout t_result r);
            logic [31:0] len;
            blk_left = blk_left - 24'd1;
            case (phase)
                PH_INFO: begin
                    if (pos >= 10) info_acc = {info_acc[23:0], b};
                    pos++;
                    if (pos == 14) begin
                        have              = 1'b1;
                        r.kind            = KIND_INFO;
                        r.sample_rate     = info_acc[31:12];
                        r.bits_per_sample = 6'(info_acc[8:4]) + 6'd1;
                        r.channel_count   = 4'(info_acc[11:9]) + 4'd1;
                        phase             = PH_SKIP;
                    end
                end
                PH_VLEN: begin
                    if (take_le(b)) begin
                        skip_left = shift_acc;
                        shift_acc = '0;
                        phase     = (skip_left != 0) ? PH_VSKIP : PH_TCOUNT;
                    end
                end
                PH_VSKIP: begin
                    skip_left--;
                    if (skip_left == 0) phase = PH_TCOUNT;
                end
                PH_TCOUNT: begin
                    if (take_le(b)) begin
                        tags_total  = shift_acc;
                        shift_acc   = '0;
                        tag_num     = '0;
                        have        = 1'b1;
                        r.kind      = KIND_COUNT;
                        r.tag_count = tags_total;
                        phase       = (tags_total != 0) ? PH_TLEN : PH_SKIP;
                    end
                end
                PH_TLEN: begin
                    if (take_le(b)) begin
                        len       = shift_acc;
                        shift_acc = '0;
                        if (len == 0) begin
                            // empty tag is only counted
                            tag_num++;
                            if (tag_num == tags_total) phase = PH_SKIP;
                        end else if (len > 32'(blk_left)) begin
                            // tag runs past the block
                            have        = 1'b1;
                            r.kind      = KIND_END;
                            r.tag_count = tags_total;
                            r.tag_index = tag_num;
                            phase       = PH_SKIP;
                        end else begin
                            tag_left = len;
                            phase    = PH_TBYTES;
                        end
                    end
                end
                PH_TBYTES: begin
                    tag_left--;
                    have            = 1'b1;
                    r.kind          = KIND_TAG;
                    r.tag_count     = tags_total;
                    r.tag_index     = tag_num;
                    r.tag_byte      = b;
                    r.tag_last_byte = (tag_left == 0);
                    if (tag_left == 0) begin
                        tag_num++;
                        phase = (tag_num == tags_total) ? PH_SKIP : PH_TLEN;
                    end
                end
                default: ;
            endcase
            if (blk_left == 0) end_block(have, r);
        endfunction

        // note an accepted byte; returns 1 when the parser was not idling
        function bit take_byte(logic [7:0] b, logic start);
            bit          have;
            bit          active;
            t_result     r;
            logic [6:0]  btype;
            have = 1'b0;
            r    = '0;
            if (start) clear_state();
            active = (phase != PH_DONE);
            case (phase)
                PH_HEAD: begin
                    shift_acc = {shift_acc[23:0], b};
                    pos++;
                    if (pos >= 4) begin
                        if (shift_acc[31:8] == ID3_MAGIC) begin
                            phase     = PH_ID3HDR;
                            skip_left = '0;
                        end else if (shift_acc == FLAC_MAGIC) begin
                            phase = PH_BHDR;
                            pos   = '0;
                        end else begin
                            have   = 1'b1;
                            r.kind = KIND_NOT_FLAC;
                            phase  = PH_DONE;
                        end
                        shift_acc = '0;
                    end
                end
                PH_ID3HDR: begin
                    // synchsafe size in bytes six to nine
                    if (pos >= 6) skip_left = {skip_left[24:0], b[6:0]};
                    pos++;
                    if (pos >= 10) begin
                        pos       = '0;
                        shift_acc = '0;
                        phase     = (skip_left != 0) ? PH_ID3SKIP : PH_MAGIC;
                    end
                end
                PH_ID3SKIP: begin
                    skip_left--;
                    if (skip_left == 0) phase = PH_MAGIC;
                end
                PH_MAGIC: begin
                    shift_acc = {shift_acc[23:0], b};
                    pos++;
                    if (pos >= 4) begin
                        if (shift_acc == FLAC_MAGIC) begin
                            phase = PH_BHDR;
                        end else begin
                            have   = 1'b1;
                            r.kind = KIND_NOT_FLAC;
                            phase  = PH_DONE;
                        end
                        pos       = '0;
                        shift_acc = '0;
                    end
                end
                PH_BHDR: begin
                    shift_acc = {shift_acc[23:0], b};
                    pos++;
                    if (pos >= 4) begin
                        btype     = shift_acc[30:24];
                        last_blk  = shift_acc[31];
                        blk_left  = shift_acc[23:0];
                        pos       = '0;
                        shift_acc = '0;
                        info_acc  = '0;
                        if (btype == BLK_STREAMINFO)   phase = PH_INFO;
                        else if (btype == BLK_VORBIS)  phase = PH_VLEN;
                        else                           phase = PH_SKIP;
                        if (blk_left == 0) end_block(have, r);
                    end
                end
                PH_DONE: ;
                default: body_byte(b, have, r);
            endcase
            if (have) awaited.push_back(r);
            return active;
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // compare a result item with the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual kind %0d",
                         $time, got.kind);
                return;
            end
            want = awaited.pop_front();
            kind_seen[int'(want.kind) % 5]++;
            cmp_field("result_kind",     32'(want.kind),            32'(got.kind));
            cmp_field("sample_rate",     32'(want.sample_rate),     32'(got.sample_rate));
            cmp_field("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
            cmp_field("channel_count",   32'(want.channel_count),   32'(got.channel_count));
            cmp_field("tag_count",       want.tag_count,            got.tag_count);
            cmp_field("tag_index",       want.tag_index,            got.tag_index);
            cmp_field("tag_byte",        32'(want.tag_byte),        32'(got.tag_byte));
            cmp_field("tag_last_byte",   32'(want.tag_last_byte),   32'(got.tag_last_byte));
            cmp_field("metadata_done",   32'(want.metadata_done),   32'(got.metadata_done));
        endfunction

    endclass

endpackage

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for flac_metadata_stream_parser_core: feeds byte streams of
// FLAC files (ID3 prefixes, bad magic, stream info, comment tags, other
// blocks, cut and restarted files, noise) with random idling on both sides
// and checks every result item against the scoreboard prediction.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fmsp_pkg::*;
    import flac_parse_sb_pkg::*;

    localparam int ITEM_TARGET  = 1300;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_TAIL   = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_file_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_result_kind;
    logic [19:0] o_sample_rate;
    logic [5:0]  o_bits_per_sample;
    logic [3:0]  o_channel_count;
    logic [31:0] o_tag_count;
    logic [31:0] o_tag_index;
    logic [7:0]  o_tag_byte;
    logic        o_tag_last_byte;
    logic        o_metadata_done;

    flac_parse_sb sb;
    t_result      out_item;
    logic [7:0]   file_bytes[$];
    logic [7:0]   blk_body[$];
    bit           send_quiet;
    int           sent_items;
    int           live_items;
    int           file_idx;
    int           cycle_count;

    flac_metadata_stream_parser_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_file_start      (i_file_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_kind     (o_result_kind),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_channel_count   (o_channel_count),
        .o_tag_count       (o_tag_count),
        .o_tag_index       (o_tag_index),
        .o_tag_byte        (o_tag_byte),
        .o_tag_last_byte   (o_tag_last_byte),
        .o_metadata_done   (o_metadata_done)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // one item over the input handshake
    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = send_quiet ? 0 : pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_file_start <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (sb.take_byte(b, s)) live_items++;
        sent_items++;
    endtask

    task automatic send_file(input bit with_start);
        foreach (file_bytes[i]) send_byte(file_bytes[i], with_start && (i == 0));
    endtask

    // hold the sender until the block has given every predicted result
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    function automatic void put_le32(logic [31:0] v);
        blk_body.push_back(v[7:0]);
        blk_body.push_back(v[15:8]);
        blk_body.push_back(v[23:16]);
        blk_body.push_back(v[31:24]);
    endfunction

    // ID3v2 prefix with a small synchsafe size and junk payload
    function automatic void add_id3();
        logic [7:0] sz[4];
        int         total;
        file_bytes.push_back(8'h49);
        file_bytes.push_back(8'h44);
        file_bytes.push_back(8'h33);
        repeat (3) file_bytes.push_back(8'($urandom));
        sz[0] = {1'($urandom), 7'd0};
        sz[1] = {1'($urandom), 7'd0};
        sz[2] = {1'($urandom), 6'd0, 1'($urandom_range(0, 9) == 0)};
        if ($urandom_range(0, 9) == 0) sz[3] = 8'($urandom);
        else sz[3] = {1'($urandom), 7'($urandom_range(0, 20))};
        total = int'({sz[2][6:0], sz[3][6:0]});
        foreach (sz[i]) file_bytes.push_back(sz[i]);
        repeat (total) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_magic(bit good);
        logic [7:0] m[4];
        m = '{8'h66, 8'h4C, 8'h61, 8'h43};
        if (!good) m[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        foreach (m[i]) file_bytes.push_back(m[i]);
    endfunction

    // one metadata block: stream info, comment block or some other type
    function automatic void add_block(bit last);
        logic [6:0]  btype;
        logic [31:0] declared;
        logic [31:0] tlen;
        int          sel;
        int          size;
        int          vlen;
        int          ntags;
        blk_body.delete();
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            btype = BLK_STREAMINFO;
            size  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 34;
            repeat (size) blk_body.push_back(8'($urandom));
        end else if (sel < 75) begin
            btype = BLK_VORBIS;
            vlen  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            put_le32(32'(vlen));
            repeat (vlen) blk_body.push_back(8'($urandom));
            ntags = $urandom_range(0, 4);
            sel   = $urandom_range(0, 99);
            if (sel < 70)      declared = 32'(ntags);
            else if (sel < 82) declared = 32'(ntags + $urandom_range(1, 3));
            else if (sel < 88) declared = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            else               declared = (ntags > 0) ? 32'(ntags - 1) : 32'd0;
            put_le32(declared);
            for (int t = 0; t < ntags; t++) begin
                sel = $urandom_range(0, 99);
                if (sel < 20)      tlen = 32'd0;
                else if (sel < 27) tlen = 32'd1000 + 32'($urandom_range(0, 32'h7FFF_FFFF));
                else               tlen = 32'($urandom_range(1, 6));
                put_le32(tlen);
                repeat ((tlen > 6) ? 3 : int'(tlen)) blk_body.push_back(8'($urandom));
            end
            size = blk_body.size();
            sel  = $urandom_range(0, 9);
            if (sel < 2) begin
                // block ends inside its own content
                size = size - $urandom_range(1, (size < 6) ? size : 6);
            end else if (sel < 4) begin
                repeat ($urandom_range(1, 5)) blk_body.push_back(8'($urandom));
                size = blk_body.size();
            end
        end else begin
            btype = ($urandom_range(0, 9) == 0) ? 7'd127 : 7'($urandom_range(1, 126));
            if (btype == BLK_VORBIS) btype = 7'd3;
            size = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            repeat (size) blk_body.push_back(8'($urandom));
        end
        file_bytes.push_back({last, btype});
        file_bytes.push_back(8'(size >> 16));
        file_bytes.push_back(8'(size >> 8));
        file_bytes.push_back(8'(size));
        for (int i = 0; i < size; i++) file_bytes.push_back(blk_body[i]);
    endfunction

    // random file, mostly well formed, sometimes noise, cut short or unstarted
    task automatic random_file();
        int nblk;
        int cut;
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom));
            send_file(1'($urandom_range(0, 1)));
        end else begin
            if ($urandom_range(0, 9) < 3) add_id3();
            add_magic($urandom_range(0, 9) != 0);
            nblk = $urandom_range(1, 4);
            for (int i = 0; i < nblk; i++)
                add_block((i == nblk - 1) && ($urandom_range(0, 19) != 0));
            // audio after the metadata
            repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
            send_file($urandom_range(0, 19) != 0);
        end
    endtask

    // directed cases
    task automatic directed_files();
        // no start flag: last block of size zero right after the magic
        file_bytes = '{8'h66, 8'h4C, 8'h61, 8'h43, 8'h81, 8'h00, 8'h00, 8'h00};
        send_file(1'b0);
        // bad magic, then a byte that must be ignored
        file_bytes = '{8'h66, 8'h4C, 8'h61, 8'h42, 8'hFF};
        send_file(1'b1);
        // last comment block: empty vendor, one tag of one byte at the end
        file_bytes = '{8'h66, 8'h4C, 8'h61, 8'h43, 8'h84, 8'h00, 8'h00, 8'h0D,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                       8'h01, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_file(1'b1);
    endtask

    // receiver with random stalls and quiet stretches
    initial begin
        int stall_left;
        int mode_left;
        bit quiet;
        i_out_ready <= 1'b0;
        stall_left = 0;
        mode_left  = 0;
        quiet      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                quiet     = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30)
                stall_left = pick_idle();
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_item.kind            = t_kind'(o_result_kind);
            out_item.sample_rate     = o_sample_rate;
            out_item.bits_per_sample = o_bits_per_sample;
            out_item.channel_count   = o_channel_count;
            out_item.tag_count       = o_tag_count;
            out_item.tag_index       = o_tag_index;
            out_item.tag_byte        = o_tag_byte;
            out_item.tag_last_byte   = o_tag_last_byte;
            out_item.metadata_done   = o_metadata_done;
            sb.check_result(out_item);
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.awaited.size());
        $display("flac_metadata_stream_parser_core verification failed");
        $finish;
    end

    // main sequence
    initial begin
        sb           = new();
        sent_items   = 0;
        live_items   = 0;
        file_idx     = 0;
        send_quiet   = 1'b0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= 8'h00;
        i_file_start <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_files();

        while (sent_items < ITEM_TARGET) begin
            if ($urandom_range(0, 4) == 0) send_quiet = ~send_quiet;
            if (file_idx % 7 == 3) wait_results_done();
            random_file();
            file_idx++;
        end

        wait_results_done();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("sent %0d bytes (%0d parsed) in %0d random files after the directed cases",
                 sent_items, live_items, file_idx);
        $display("results: %0d stream info, %0d tag count, %0d tag byte, %0d not flac, %0d end",
                 sb.kind_seen[int'(KIND_INFO)], sb.kind_seen[int'(KIND_COUNT)],
                 sb.kind_seen[int'(KIND_TAG)], sb.kind_seen[int'(KIND_NOT_FLAC)],
                 sb.kind_seen[int'(KIND_END)]);
        if (sb.errors == 0) begin
            $display("flac_metadata_stream_parser_core verification clean");
        end else begin
            $display("flac_metadata_stream_parser_core verification failed");
        end
        $finish;
    end

endmodule
